// ===== rtl/core/lbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types, constants and helpers for the label border detector.
// ----------------------------------------------------------------------------
package lbd_pkg;

    // Storage geometry
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;
    localparam int MAP_DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(MAP_DEPTH);

    // Field widths
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int LIM_W      = 7;
    localparam int RANGE_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_RANGE = 2'd2;

    // Configuration reset values
    localparam logic [LIM_W-1:0]   RST_GRID_ROWS    = 7'd64;
    localparam logic [LIM_W-1:0]   RST_GRID_COLUMNS = 7'd64;
    localparam logic [RANGE_W-1:0] RST_BORDER_RANGE = 6'd2;

    // Scan directions, in scan order
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Input transaction payload
    typedef struct packed {
        logic             cmd;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_column;
        logic             label_value;
    } t_lbd_in;

    // Result transaction payload
    typedef struct packed {
        logic             is_border;
        logic [ROW_W-1:0] queried_row;
        logic [COL_W-1:0] queried_column;
    } t_lbd_out;

    // Controller to datapath commands
    typedef struct packed {
        logic map_wr;    // store the accepted label
        logic load;      // capture the accepted query
        logic own_rd;    // read the queried cell
        logic own_cap;   // capture own label, arm the scan
        logic scan;      // one scan step
        logic out_load;  // load the result register
    } t_lbd_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_grid;   // incoming query lies inside the grid in use
        logic done;      // scan finished or a differing label found
    } t_lbd_sts;

    // Map address: row * MAX_COLUMNS + column
    function automatic logic [ADDR_W-1:0] map_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        map_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLUMNS)) + ADDR_W'(col);
    endfunction

endpackage

// ===== rtl/core/lbd_ram.sv =====
// ----------------------------------------------------------------------------
// lbd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lbd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbd_ctrl
// Sequencer for the label border detector: takes transactions, steps the
// neighbour scan and hands results to the output register.
// ----------------------------------------------------------------------------
module lbd_ctrl
    import lbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_cmd,
    input  logic     i_out_stall,
    input  t_lbd_sts i_sts,
    output t_lbd_cmd o_cmd,
    output logic     o_in_stall,
    output logic     o_out_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OWN  = 3'd1;
    localparam logic [2:0] S_CAP  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;
    t_lbd_cmd   cmd;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_cmd == CMD_QUERY) begin
                        cmd.load = 1'b1;
                        n_state  = i_sts.in_grid ? S_OWN : S_FIN;
                    end else begin
                        cmd.map_wr = 1'b1;
                    end
                end
            end
            S_OWN: begin
                cmd.own_rd = 1'b1;
                n_state    = S_CAP;
            end
            S_CAP: begin
                cmd.own_cap = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_sts.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an untaken result");

    a_query_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_cmd == CMD_QUERY && i_sts.in_grid) |=> (r_state == S_OWN))
        else $error("in-grid query did not start the own-cell read");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside the finish state");

endmodule

// ===== rtl/core/lbd_dp.sv =====
// ----------------------------------------------------------------------------
// lbd_dp
// Datapath for the label border detector: configuration registers, label
// map, scan position and direction, and the result register.
// ----------------------------------------------------------------------------
module lbd_dp
    import lbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_lbd_in               i_in,
    input  t_lbd_cmd              i_cmd,
    output t_lbd_sts              o_sts,
    output t_lbd_out              o_out
);

    // Configuration
    logic [LIM_W-1:0]   r_grid_rows;
    logic [LIM_W-1:0]   r_grid_cols;
    logic [RANGE_W-1:0] r_range;

    // Query and scan state
    logic [ROW_W-1:0]   r_q_row;
    logic [COL_W-1:0]   r_q_col;
    logic               r_own;
    logic               r_border;
    logic [1:0]         r_dir;
    logic [RANGE_W-1:0] r_step;
    logic [ROW_W-1:0]   r_pos_row;
    logic [COL_W-1:0]   r_pos_col;
    logic               r_chk_valid;
    logic               r_scan_active;
    t_lbd_out           r_out;

    logic [LIM_W-1:0]   rows_lim;
    logic [LIM_W-1:0]   cols_lim;
    logic [ROW_W-1:0]   cand_row;
    logic [COL_W-1:0]   cand_col;
    logic               at_bound;
    logic               can_issue;
    logic               differ;
    logic               map_we;
    logic [ADDR_W-1:0]  raddr;
    logic               rdata;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= RST_GRID_ROWS;
            r_grid_cols <= RST_GRID_COLUMNS;
            r_range     <= RST_BORDER_RANGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_ROWS:    r_grid_rows <= i_cfg_data;
                CFG_GRID_COLUMNS: r_grid_cols <= i_cfg_data;
                CFG_BORDER_RANGE: r_range     <= i_cfg_data[RANGE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Grid in use, clipped to storage
    assign rows_lim = (r_grid_rows > LIM_W'(MAX_ROWS))    ? LIM_W'(MAX_ROWS)    : r_grid_rows;
    assign cols_lim = (r_grid_cols > LIM_W'(MAX_COLUMNS)) ? LIM_W'(MAX_COLUMNS) : r_grid_cols;

    assign o_sts.in_grid = ({1'b0, i_in.cell_row} < rows_lim) &&
                           ({1'b0, i_in.cell_column} < cols_lim);

    // Next cell along the current direction
    always_comb begin
        cand_row = r_pos_row;
        cand_col = r_pos_col;
        at_bound = 1'b0;
        unique case (r_dir)
            DIR_LEFT: begin
                at_bound = (r_pos_col == '0);
                cand_col = r_pos_col - COL_W'(1);
            end
            DIR_RIGHT: begin
                at_bound = (LIM_W'({1'b0, r_pos_col}) + LIM_W'(1) >= cols_lim);
                cand_col = r_pos_col + COL_W'(1);
            end
            DIR_UP: begin
                at_bound = (r_pos_row == '0);
                cand_row = r_pos_row - ROW_W'(1);
            end
            DIR_DOWN: begin
                at_bound = (LIM_W'({1'b0, r_pos_row}) + LIM_W'(1) >= rows_lim);
                cand_row = r_pos_row + ROW_W'(1);
            end
            default: ;
        endcase
    end

    assign can_issue = r_scan_active && (r_step < r_range) && !at_bound;
    assign differ    = r_chk_valid && (rdata != r_own);

    assign o_sts.done = r_border || differ || (!r_scan_active && !r_chk_valid);

    // Label map
    assign map_we = i_cmd.map_wr &&
                    ({1'b0, i_in.cell_row} < LIM_W'(MAX_ROWS)) &&
                    ({1'b0, i_in.cell_column} < LIM_W'(MAX_COLUMNS));
    assign raddr  = i_cmd.own_rd ? map_addr(r_q_row, r_q_col) : map_addr(cand_row, cand_col);

    lbd_ram #(
        .WIDTH(1),
        .DEPTH(MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_addr(i_in.cell_row, i_in.cell_column)),
        .i_wdata (i_in.label_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Scan control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_active <= 1'b0;
            r_chk_valid   <= 1'b0;
            r_border      <= 1'b0;
        end else if (i_cmd.load) begin
            r_scan_active <= 1'b0;
            r_chk_valid   <= 1'b0;
            r_border      <= 1'b0;
        end else if (i_cmd.own_cap) begin
            r_scan_active <= 1'b1;
            r_chk_valid   <= 1'b0;
        end else if (i_cmd.scan) begin
            if (differ) begin
                r_border <= 1'b1;
            end
            r_chk_valid <= can_issue;
            if (!can_issue && r_dir == DIR_DOWN) begin
                r_scan_active <= 1'b0;
            end
        end
    end

    // Query capture and scan position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q_row <= i_in.cell_row;
            r_q_col <= i_in.cell_column;
        end
        if (i_cmd.own_cap) begin
            r_own     <= rdata;
            r_dir     <= DIR_LEFT;
            r_step    <= '0;
            r_pos_row <= r_q_row;
            r_pos_col <= r_q_col;
        end else if (i_cmd.scan && r_scan_active) begin
            if (can_issue) begin
                r_pos_row <= cand_row;
                r_pos_col <= cand_col;
                r_step    <= r_step + RANGE_W'(1);
            end else if (r_dir != DIR_DOWN) begin
                r_dir     <= r_dir + 2'd1;
                r_step    <= '0;
                r_pos_row <= r_q_row;
                r_pos_col <= r_q_col;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.is_border      <= r_border;
            r_out.queried_row    <= r_q_row;
            r_out.queried_column <= r_q_col;
        end
    end

    assign o_out = r_out;

    // Checks
    a_chk_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> r_scan_active)
        else $error("pending label check with no scan running");

    a_border_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_border) |-> $past(i_cmd.scan))
        else $error("border flag set outside a scan step");

endmodule

// ===== rtl/core/label_border_detector.sv =====
// ----------------------------------------------------------------------------
// label_border_detector
// Grid map of one-bit region labels with a straight-line border query.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_in  (t_lbd_in)
//   result    out        o_out_valid / i_out_stall o_out (t_lbd_out)
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A write transaction is taken while idle and gives no result. A query
// inside the grid reads the queried cell, then scans up to border_range
// cells left, right, up and down, one map read per cycle through the single
// read port; a differing label ends the scan early. An outside query skips the scan.
// Reset is synchronous and active low; the map is not cleared.
// The next transaction waits while a query is in progress; a stalled result
// holds in the output register and does not block write transactions.
// ----------------------------------------------------------------------------
module label_border_detector
    import lbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_lbd_in               i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_lbd_out              o_out
);

    t_lbd_cmd cmd;
    t_lbd_sts sts;

    // Sequencer
    lbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in.cmd),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Datapath
    lbd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for label_border_detector. Label writes and border
// queries are queued by the stimulus process and driven by a clocked driver.
// Accepted transactions update a shadow label map, and each query's expected
// answer is queued. A clocked monitor compares every result transaction
// with the oldest expected answer, field by field. Both sides insert random
// idle and stall cycles. Grid size and border range are swept between
// phases, and only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import lbd_pkg::*;

    localparam int SETTLE_CYCLES = 4 * 63 + 16;   // longest query plus margin
    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int MAX_WAIT      = 14;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_lbd_in               i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_lbd_out              o_out;

    label_border_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Shadow of the label map and of the configuration registers
    bit          label_shadow [MAP_DEPTH];
    int unsigned rows_cfg  = RST_GRID_ROWS;
    int unsigned cols_cfg  = RST_GRID_COLUMNS;
    int unsigned range_cfg = RST_BORDER_RANGE;

    t_lbd_out    border_expect [$];   // answers still owed by the block
    t_lbd_in     item_backlog [$];    // transactions not yet driven
    bit          cell_known [MAP_DEPTH];
    int unsigned label_density = 50;  // percent chance of label 1
    int unsigned fault_count   = 0;
    int unsigned cycle_count   = 0;

    int unsigned sender_gap      = 0;
    bit          sender_bursty   = 1'b0;
    int unsigned receiver_hold   = 0;
    int unsigned hold_draw;
    bit          receiver_bursty = 1'b0;

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Grid extent actually in use, clamped to the storage size
    function automatic int rows_in_use();
        return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    endfunction

    function automatic int cols_in_use();
        return (cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_cfg);
    endfunction

    // Look along the four straight lines for a differing label
    function automatic bit scan_for_border(input int row, input int col);
        int step_row [4];
        int step_col [4];
        int r, c, d, i;
        bit own, found, in_line;
        step_row = '{0, 0, -1, 1};
        step_col = '{-1, 1, 0, 0};
        found = 1'b0;
        if (row < rows_in_use() && col < cols_in_use()) begin
            own = label_shadow[row * MAX_COLUMNS + col];
            for (d = 0; d < 4; d++) begin
                r = row;
                c = col;
                in_line = 1'b1;
                for (i = 1; i <= int'(range_cfg) && in_line; i++) begin
                    r += step_row[d];
                    c += step_col[d];
                    if (r < 0 || c < 0 || r >= rows_in_use() || c >= cols_in_use())
                        in_line = 1'b0;
                    else if (label_shadow[r * MAX_COLUMNS + c] != own)
                        found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    // Apply one accepted transaction to the shadow map
    task automatic shadow_accept(input t_lbd_in item);
        t_lbd_out answer;
        if (item.cmd == CMD_WRITE) begin
            label_shadow[int'(item.cell_row) * MAX_COLUMNS + int'(item.cell_column)] =
                item.label_value;
        end else begin
            answer.is_border      = scan_for_border(item.cell_row, item.cell_column);
            answer.queried_row    = item.cell_row;
            answer.queried_column = item.cell_column;
            border_expect.push_back(answer);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(input t_lbd_out got);
        t_lbd_out want;
        if (border_expect.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                     $time, got.is_border, got.queried_row, got.queried_column);
        end else begin
            want = border_expect.pop_front();
            compare_field("is_border", want.is_border, got.is_border);
            compare_field("queried_row", want.queried_row, got.queried_row);
            compare_field("queried_column", want.queried_column, got.queried_column);
        end
    endtask

    // Stimulus helpers
    function automatic logic draw_label();
        return ($urandom_range(0, 99) < label_density);
    endfunction

    task automatic queue_write(input int row, input int col, input logic lab);
        t_lbd_in item;
        item.cmd         = CMD_WRITE;
        item.cell_row    = row[ROW_W-1:0];
        item.cell_column = col[COL_W-1:0];
        item.label_value = lab;
        item_backlog.push_back(item);
        cell_known[row * MAX_COLUMNS + col] = 1'b1;
    endtask

    // Every cell the query may read is written first
    task automatic queue_query(input int row, input int col);
        int step_row [4];
        int step_col [4];
        int r, c, d, i;
        bit in_line;
        t_lbd_in item;
        step_row = '{0, 0, -1, 1};
        step_col = '{-1, 1, 0, 0};
        if (row < rows_in_use() && col < cols_in_use()) begin
            if (!cell_known[row * MAX_COLUMNS + col])
                queue_write(row, col, draw_label());
            for (d = 0; d < 4; d++) begin
                r = row;
                c = col;
                in_line = 1'b1;
                for (i = 1; i <= int'(range_cfg) && in_line; i++) begin
                    r += step_row[d];
                    c += step_col[d];
                    if (r < 0 || c < 0 || r >= rows_in_use() || c >= cols_in_use())
                        in_line = 1'b0;
                    else if (!cell_known[r * MAX_COLUMNS + c])
                        queue_write(r, c, draw_label());
                end
            end
        end
        item.cmd         = CMD_QUERY;
        item.cell_row    = row[ROW_W-1:0];
        item.cell_column = col[COL_W-1:0];
        item.label_value = $urandom_range(0, 1);
        item_backlog.push_back(item);
    endtask

    task automatic queue_batch(input int count);
        int n, ru, cu;
        ru = rows_in_use();
        cu = cols_in_use();
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 55) begin
                if (ru > 0 && cu > 0 && $urandom_range(0, 3) != 0)
                    queue_query($urandom_range(0, ru - 1), $urandom_range(0, cu - 1));
                else
                    queue_query($urandom_range(0, 63), $urandom_range(0, 63));
            end else begin
                queue_write($urandom_range(0, 63), $urandom_range(0, 63), draw_label());
            end
        end
    endtask

    // Idle means nothing queued, nothing driven and no answer owed
    task automatic wait_for_drain();
        while (item_backlog.size() != 0 || i_in_valid || border_expect.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            CFG_GRID_ROWS:    rows_cfg  = value & 32'h7f;
            CFG_GRID_COLUMNS: cols_cfg  = value & 32'h7f;
            CFG_BORDER_RANGE: range_cfg = value & 32'h3f;
            default: ;
        endcase
    endtask

    task automatic run_phase(input int unsigned rows, input int unsigned cols,
                             input int unsigned span, input int unsigned density,
                             input int count);
        wait_for_drain();
        write_register(CFG_GRID_ROWS, rows);
        write_register(CFG_GRID_COLUMNS, cols);
        write_register(CFG_BORDER_RANGE, span);
        @(negedge i_clk);
        label_density = density;
        queue_batch(count);
    endtask

    // Stimulus sequence
    initial begin
        int unsigned densities [5];
        int k;
        densities = '{0, 10, 50, 90, 100};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: uniform corner, then a differing label at full range
        queue_write(0, 0, 1'b0);
        queue_write(0, 1, 1'b0);
        queue_write(0, 2, 1'b0);
        queue_write(1, 0, 1'b0);
        queue_write(2, 0, 1'b0);
        queue_query(0, 0);
        queue_write(2, 0, 1'b1);
        queue_query(0, 0);
        // opposite corner, differing label two cells to the left
        queue_write(63, 63, 1'b1);
        queue_write(63, 62, 1'b1);
        queue_write(63, 61, 1'b0);
        queue_write(62, 63, 1'b1);
        queue_write(61, 63, 1'b1);
        queue_query(63, 63);
        queue_query(0, 63);
        queue_query(31, 32);
        queue_batch(50);

        // Register sweeps: extremes, oversize grid, empty grid, zero range
        run_phase(1, 1, 1, 50, 30);
        run_phase(64, 64, 63, 97, 4);
        run_phase(127, 127, 0, 50, 30);
        run_phase(0, 64, 5, 50, 20);
        run_phase(5, 0, 5, 50, 20);
        run_phase(64, 1, 63, 90, 30);
        run_phase(1, 64, 63, 90, 30);
        for (k = 0; k < 5; k++)
            run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 6),
                      densities[$urandom_range(0, 4)], 20);
        run_phase(64, 64, 2, 20, 50);

        wait_for_drain();
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Driver: one transaction at a time, random gap before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            sender_gap <= 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                shadow_accept(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (sender_gap != 0) begin
                    sender_gap <= sender_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (item_backlog.size() != 0) begin
                    i_in       <= item_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        sender_bursty <= !sender_bursty;
                    sender_gap <= sender_bursty ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result, then stall for a random count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall   <= 1'b0;
            receiver_hold <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            check_result(o_out);
            if ($urandom_range(0, 19) == 0)
                receiver_bursty <= !receiver_bursty;
            hold_draw = receiver_bursty ? 0 : $urandom_range(0, MAX_WAIT);
            receiver_hold <= hold_draw;
            i_out_stall   <= (hold_draw != 0);
        end else if (receiver_hold != 0) begin
            receiver_hold <= receiver_hold - 1;
            i_out_stall   <= (receiver_hold > 1);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/lbd_pkg.sv
rtl/core/lbd_ram.sv
rtl/core/lbd_ctrl.sv
rtl/core/lbd_dp.sv
rtl/core/label_border_detector.sv
verif/testbench.sv
